>>> src/wqe_pkg.sv
// ============================================================================
// wqe_pkg: shared definitions for the wait queue engine
// Sizes, request and status codes, sequencer states and the result struct.
// ============================================================================
`default_nettype none

package wqe_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int THREAD_BITS = 8;
   localparam longint unsigned MISSED_MAX = 65535;

   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int MISSED_BITS = (MISSED_MAX > 1) ? $clog2(MISSED_MAX + 1) : 1;
   localparam int ENTRY_BITS  = THREAD_BITS + 1;

   typedef enum logic [1:0] {
      REQ_SLEEP   = 2'd0,
      REQ_WAKEUP  = 2'd1,
      REQ_TIMEOUT = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK_ATOMIC   = 3'd0,
      ST_WOULD_BLOCK = 3'd1,
      ST_ENQUEUED    = 3'd2,
      ST_WOKEN       = 3'd3,
      ST_TIMED_OUT   = 3'd4,
      ST_NO_WAITER   = 3'd5,
      ST_IGNORED     = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_WAKE_RD,
      S_WAKE_EMIT,
      S_ALL_DONE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_REMOVE_END,
      S_FINISH
   } state_type;

   // one result transaction handed from the sequencer to the output register
   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [7:0]  out_thread;
      logic        arm_timer;
      logic [31:0] timer_value;
      logic        cancel_timer;
      logic [15:0] missed_now;
      logic        last;
   } emit_type;

endpackage

`default_nettype wire

>>> src/wqe_req_if.sv
// ============================================================================
// wqe_req_if: request channel of the wait queue engine
// Valid/ready handshake carrying one sleep, wakeup or timeout transaction.
// ============================================================================
`default_nettype none

interface wqe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  thread_id;
   logic [31:0] timeout_us;
   logic        nonblocking;
   logic        wake_all;

   modport source (
      output valid, req_type, thread_id, timeout_us, nonblocking, wake_all,
      input  ready
   );
   modport sink (
      input  valid, req_type, thread_id, timeout_us, nonblocking, wake_all,
      output ready
   );
endinterface

`default_nettype wire

>>> src/wqe_rsp_if.sv
// ============================================================================
// wqe_rsp_if: result channel of the wait queue engine
// Valid/ready handshake carrying one result transaction.
// ============================================================================
`default_nettype none

interface wqe_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  out_thread;
   logic        arm_timer;
   logic [31:0] timer_value;
   logic        cancel_timer;
   logic [15:0] missed_now;
   logic        last;

   modport source (
      output valid, status, out_thread, arm_timer, timer_value, cancel_timer,
             missed_now, last,
      input  ready
   );
   modport sink (
      input  valid, status, out_thread, arm_timer, timer_value, cancel_timer,
             missed_now, last,
      output ready
   );
endinterface

`default_nettype wire

>>> src/wait_queue_engine_top.sv
// ============================================================================
// wait_queue_engine_top: hardware wait queue with missed-wakeup counter
// Top level: request sequencer plus the result output register.
// ============================================================================
// A FIFO of up to QUEUE_DEPTH sleeping thread ids, each with a timer-armed
// bit, plus a saturating missed-wakeup counter. One request transaction is
// taken at a time; req_bus.ready is low from acceptance until the last result
// of that request has been loaded into the output register, and a new request
// can be taken in the cycle after that. Sleep, unknown requests, a timeout and
// a wakeup on an empty queue give one result, as does a single wakeup that
// finds a sleeper. Wake-all gives one woken result per queued sleeper
// followed by a no_waiter result. A timeout compares the entries one at a
// time up to the match and then moves each younger entry down to close the
// gap. The sleeper RAM has a single registered read port, which the
// sequencer walks one entry at a time; a stalled rsp_bus holds the sequencer.
// The RAM needs no clearing after reset: only entries below the fill count
// are ever read.
// ============================================================================
`default_nettype none

module wait_queue_engine_top (
   input  wire logic clock,
   input  wire logic reset,
   wqe_req_if.sink   req_bus,
   wqe_rsp_if.source rsp_bus
);

   wqe_pkg::emit_type emit;
   wqe_pkg::emit_type rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   // output register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   wqe_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .slot_free (slot_free),
      .emit      (emit)
   );

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_data_in  = emit;
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_data_ff.status;
   assign rsp_bus.out_thread   = rsp_data_ff.out_thread;
   assign rsp_bus.arm_timer    = rsp_data_ff.arm_timer;
   assign rsp_bus.timer_value  = rsp_data_ff.timer_value;
   assign rsp_bus.cancel_timer = rsp_data_ff.cancel_timer;
   assign rsp_bus.missed_now   = rsp_data_ff.missed_now;
   assign rsp_bus.last         = rsp_data_ff.last;

   // a new request transaction is never taken while one is in progress
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request accepted while previous one still in progress");

   // results are only loaded when the output register can take them
   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> slot_free)
      else $error("result loaded over an undelivered result");

   // the last result of a request frees the request side
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      emit.valid && emit.last |=> req_bus.ready)
      else $error("request side not ready after last result");

   // intermediate wake-all results keep the request side closed
   a_busy_mid_burst: assert property (@(posedge clock) disable iff (reset)
      emit.valid && !emit.last |=> !req_bus.ready)
      else $error("request side opened in the middle of a wake-all burst");

endmodule

`default_nettype wire

>>> src/wqe_ram.sv
// ============================================================================
// wqe_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module wqe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> src/wqe_seq.sv
// ============================================================================
// wqe_seq: wait queue sequencer
// Circular queue of sleepers in RAM, walked one entry at a time by a single
// id comparator and pointer stepper.
// ============================================================================
`default_nettype none

module wqe_seq (
   input  wire logic         clock,
   input  wire logic         reset,
   wqe_req_if.sink           req_bus,
   input  wire logic         slot_free,
   output wqe_pkg::emit_type emit
);

   localparam int PB = wqe_pkg::PTR_BITS;
   localparam int CB = wqe_pkg::CNT_BITS;
   localparam int TB = wqe_pkg::THREAD_BITS;
   localparam int MB = wqe_pkg::MISSED_BITS;
   localparam int EB = wqe_pkg::ENTRY_BITS;

   // step a physical pointer with wrap
   function automatic logic [PB-1:0] ptr_inc(input logic [PB-1:0] p);
      if (p == PB'(wqe_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PB'(1);
   endfunction

   wqe_pkg::state_type  state_ff, state_in;
   logic [CB-1:0]       count_ff, count_in;
   logic [PB-1:0]       head_ff, head_in;
   logic [PB-1:0]       tail_ff, tail_in;
   logic [MB-1:0]       missed_ff, missed_in;
   logic [PB-1:0]       ptr_ff, ptr_in;
   logic [CB-1:0]       idx_ff, idx_in;

   logic [1:0]          kind_ff, kind_in;
   logic [TB-1:0]       tid_ff, tid_in;
   logic [31:0]         tmo_ff, tmo_in;
   logic                nonblk_ff, nonblk_in;
   logic                all_ff, all_in;
   wqe_pkg::status_type pend_status_ff, pend_status_in;
   logic [7:0]          pend_thread_ff, pend_thread_in;
   logic                pend_arm_ff, pend_arm_in;

   logic                ram_we;
   logic [PB-1:0]       ram_waddr;
   logic [EB-1:0]       ram_wdata;
   logic [PB-1:0]       ram_raddr;
   logic [EB-1:0]       ram_rdata;
   logic                id_match;

   wqe_ram #(
      .WIDTH (EB),
      .DEPTH (wqe_pkg::QUEUE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // the shared comparator
   assign id_match = (ram_rdata[TB-1:0] == tid_ff);

   assign req_bus.ready = (state_ff == wqe_pkg::S_IDLE);

   always_comb begin
      case (state_ff)
         wqe_pkg::S_WAKE_RD, wqe_pkg::S_WAKE_EMIT: ram_raddr = head_ff;
         wqe_pkg::S_SHIFT_RD:                      ram_raddr = ptr_inc(ptr_ff);
         default:                                  ram_raddr = ptr_ff;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      missed_in      = missed_ff;
      ptr_in         = ptr_ff;
      idx_in         = idx_ff;
      kind_in        = kind_ff;
      tid_in         = tid_ff;
      tmo_in         = tmo_ff;
      nonblk_in      = nonblk_ff;
      all_in         = all_ff;
      pend_status_in = pend_status_ff;
      pend_thread_in = pend_thread_ff;
      pend_arm_in    = pend_arm_ff;
      ram_we         = 1'b0;
      ram_waddr      = ptr_ff;
      ram_wdata      = ram_rdata;
      emit           = '0;

      case (state_ff)
         wqe_pkg::S_IDLE: begin
            if (req_bus.valid) begin
               kind_in   = req_bus.req_type;
               tid_in    = TB'(req_bus.thread_id);
               tmo_in    = req_bus.timeout_us;
               nonblk_in = req_bus.nonblocking;
               all_in    = req_bus.wake_all;
               state_in  = wqe_pkg::S_DISPATCH;
            end
         end

         wqe_pkg::S_DISPATCH: begin
            pend_thread_in = 8'(tid_ff);
            pend_arm_in    = 1'b0;
            state_in       = wqe_pkg::S_FINISH;
            case (kind_ff)
               wqe_pkg::REQ_SLEEP: begin
                  if (missed_ff != '0) begin
                     missed_in      = missed_ff - MB'(1);
                     pend_status_in = wqe_pkg::ST_OK_ATOMIC;
                  end else if (nonblk_ff && (tmo_ff == '0)) begin
                     pend_status_in = wqe_pkg::ST_WOULD_BLOCK;
                  end else if (count_ff == CB'(wqe_pkg::QUEUE_DEPTH)) begin
                     pend_status_in = wqe_pkg::ST_IGNORED;
                  end else begin
                     ram_we         = 1'b1;
                     ram_waddr      = tail_ff;
                     ram_wdata      = {(tmo_ff != '0), tid_ff};
                     tail_in        = ptr_inc(tail_ff);
                     count_in       = count_ff + CB'(1);
                     pend_status_in = wqe_pkg::ST_ENQUEUED;
                     pend_arm_in    = (tmo_ff != '0);
                  end
               end
               wqe_pkg::REQ_WAKEUP: begin
                  if (count_ff != '0) begin
                     state_in = wqe_pkg::S_WAKE_RD;
                  end else if (all_ff) begin
                     state_in = wqe_pkg::S_ALL_DONE;
                  end else begin
                     if (missed_ff != MB'(wqe_pkg::MISSED_MAX)) begin
                        missed_in = missed_ff + MB'(1);
                     end
                     pend_status_in = wqe_pkg::ST_NO_WAITER;
                     pend_thread_in = '0;
                  end
               end
               wqe_pkg::REQ_TIMEOUT: begin
                  if (count_ff == '0) begin
                     pend_status_in = wqe_pkg::ST_IGNORED;
                  end else begin
                     ptr_in   = head_ff;
                     idx_in   = '0;
                     state_in = wqe_pkg::S_SCAN_RD;
                  end
               end
               default: begin
                  pend_status_in = wqe_pkg::ST_IGNORED;
                  pend_thread_in = '0;
               end
            endcase
         end

         wqe_pkg::S_WAKE_RD: begin
            state_in = wqe_pkg::S_WAKE_EMIT;
         end

         wqe_pkg::S_WAKE_EMIT: begin
            if (slot_free) begin
               emit.valid        = 1'b1;
               emit.status       = wqe_pkg::ST_WOKEN;
               emit.out_thread   = 8'(ram_rdata[TB-1:0]);
               emit.cancel_timer = ram_rdata[TB];
               emit.missed_now   = 16'(missed_ff);
               emit.last         = !all_ff;
               head_in           = ptr_inc(head_ff);
               count_in          = count_ff - CB'(1);
               if (!all_ff) begin
                  state_in = wqe_pkg::S_IDLE;
               end else if (count_ff == CB'(1)) begin
                  state_in = wqe_pkg::S_ALL_DONE;
               end else begin
                  state_in = wqe_pkg::S_WAKE_RD;
               end
            end
         end

         wqe_pkg::S_ALL_DONE: begin
            if (slot_free) begin
               emit.valid  = 1'b1;
               emit.status = wqe_pkg::ST_NO_WAITER;
               emit.last   = 1'b1;
               missed_in   = '0;
               state_in    = wqe_pkg::S_IDLE;
            end
         end

         wqe_pkg::S_SCAN_RD: begin
            state_in = wqe_pkg::S_SCAN_CHK;
         end

         wqe_pkg::S_SCAN_CHK: begin
            if (id_match) begin
               // close the gap by pulling the younger entries down one slot
               if ((idx_ff + CB'(1)) < count_ff) begin
                  state_in = wqe_pkg::S_SHIFT_RD;
               end else begin
                  state_in = wqe_pkg::S_REMOVE_END;
               end
            end else if ((idx_ff + CB'(1)) >= count_ff) begin
               pend_status_in = wqe_pkg::ST_IGNORED;
               pend_thread_in = 8'(tid_ff);
               pend_arm_in    = 1'b0;
               state_in       = wqe_pkg::S_FINISH;
            end else begin
               idx_in   = idx_ff + CB'(1);
               ptr_in   = ptr_inc(ptr_ff);
               state_in = wqe_pkg::S_SCAN_RD;
            end
         end

         wqe_pkg::S_SHIFT_RD: begin
            state_in = wqe_pkg::S_SHIFT_WR;
         end

         wqe_pkg::S_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ram_wdata = ram_rdata;
            ptr_in    = ptr_inc(ptr_ff);
            idx_in    = idx_ff + CB'(1);
            if ((idx_ff + CB'(2)) < count_ff) begin
               state_in = wqe_pkg::S_SHIFT_RD;
            end else begin
               state_in = wqe_pkg::S_REMOVE_END;
            end
         end

         wqe_pkg::S_REMOVE_END: begin
            tail_in        = ptr_ff;
            count_in       = count_ff - CB'(1);
            pend_status_in = wqe_pkg::ST_TIMED_OUT;
            pend_thread_in = 8'(tid_ff);
            pend_arm_in    = 1'b0;
            state_in       = wqe_pkg::S_FINISH;
         end

         wqe_pkg::S_FINISH: begin
            if (slot_free) begin
               emit.valid       = 1'b1;
               emit.status      = pend_status_ff;
               emit.out_thread  = pend_thread_ff;
               emit.arm_timer   = pend_arm_ff;
               emit.timer_value = pend_arm_ff ? tmo_ff : 32'd0;
               emit.missed_now  = 16'(missed_ff);
               emit.last        = 1'b1;
               state_in         = wqe_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = wqe_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= wqe_pkg::S_IDLE;
         count_ff  <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         missed_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         missed_ff <= missed_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      idx_ff         <= idx_in;
      kind_ff        <= kind_in;
      tid_ff         <= tid_in;
      tmo_ff         <= tmo_in;
      nonblk_ff      <= nonblk_in;
      all_ff         <= all_in;
      pend_status_ff <= pend_status_in;
      pend_thread_ff <= pend_thread_in;
      pend_arm_ff    <= pend_arm_in;
   end

endmodule

`default_nettype wire
